// File: rtl/cfs_pkg.sv
// Shared types, widths and codes for the Coulomb field superposition block.
// Depends on nothing; every other file of the block but cfs_ram imports it.
`timescale 1ns / 1ps
package cfs_pkg;

  localparam int MAX_CHARGES_DEF = 16;

  localparam int POS_W  = 16;  // Q12.4 position
  localparam int STR_W  = 32;  // Q16.16 strength
  localparam int IDX_W  = 4;
  localparam int DIFF_W = 17;  // difference of two positions
  localparam int SQ_W   = 32;  // square of a difference
  localparam int D_W    = 33;  // squared distance, Q25.8
  localparam int ROOT_W = 21;  // distance, Q13.8
  localparam int DEN_W  = D_W + ROOT_W;          // 54
  localparam int PRD_W  = STR_W + DIFF_W;        // 49
  localparam int NUM_W  = PRD_W + 12;            // 61, signed
  localparam int MAG_W  = NUM_W - 1;             // 60
  localparam int ACC_W  = 42;                    // running sum, clamped to -2^40 .. 2^40-1
  localparam int OUT_W  = 32;
  localparam int RAM_W  = 2 * POS_W + STR_W;     // one table entry

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_EXCL   = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  localparam logic [4:0]  ACTIVE_RST = 5'd0;
  localparam logic [31:0] EXCL_RST   = 32'd1;
  localparam logic [31:0] SCALE_RST  = 32'd65536;

  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [STR_W-1:0] s;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] fx;
    logic signed [OUT_W-1:0] fy;
    logic signed [OUT_W-1:0] ax;
    logic signed [OUT_W-1:0] ay;
    logic                    sat;
  } res_t;

endpackage

// File: rtl/cfs_ram.sv
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module cfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/cfs_front.sv
// Front end: accepts input beats, drops out-of-table loads, queues the rest.
// Depends on cfs_pkg.
`timescale 1ns / 1ps
module cfs_front #(
  parameter int MAX_CHARGES = cfs_pkg::MAX_CHARGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  cfs_pkg::item_t item,
  output logic           q_valid,
  output cfs_pkg::item_t q_item,
  input  logic           q_pop
);
  import cfs_pkg::*;

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       keep;
  logic       acc;

  assign full    = (cnt_r == 2'd2);
  assign acc     = push && !full;
  // drop loads aimed beyond the table
  assign keep    = (item.kind == KIND_QUERY) || (32'(item.idx) < MAX_CHARGES);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (acc && keep) begin
      ent_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc && keep) begin
        wp_r <= !wp_r;
      end
      if (q_pop && q_valid) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'((acc && keep) ? 1 : 0) - 2'((q_pop && q_valid) ? 1 : 0);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |=> cnt_r != 2'd3)
    else $error("queue count overflow");
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 && !(push && keep) |=> cnt_r == 2'd0)
    else $error("queue filled without push");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r)
    else $error("pointers disagree with count");
`endif

endmodule

// File: rtl/cfs_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on cfs_pkg.
`timescale 1ns / 1ps
module cfs_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [cfs_pkg::NUM_W-1:0]  num,
  input  logic        [cfs_pkg::DEN_W-1:0]  den,
  output logic                              done,
  output logic signed [cfs_pkg::NUM_W-1:0]  quot
);
  import cfs_pkg::*;

  localparam int CW = $clog2(MAG_W + 1);

  logic [MAG_W-1:0] nq_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;
  logic [NUM_W-1:0] num_abs;

  assign num_abs = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign rem_sh  = {rem_r[DEN_W-1:0], nq_r[MAG_W-1]};
  assign qbit    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num_abs[MAG_W-1:0];
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      rem_r <= qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
      nq_r  <= {nq_r[MAG_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, nq_r}) : $signed({1'b0, nq_r});

endmodule

// File: rtl/cfs_back.sv
// Back end: writes table entries and runs the per-charge field sum for queries.
// Depends on cfs_pkg, cfs_ram and cfs_div.
`timescale 1ns / 1ps
module cfs_back #(
  parameter int MAX_CHARGES = cfs_pkg::MAX_CHARGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  cfs_pkg::item_t       q_item,
  output logic                 q_pop,
  input  logic [4:0]           active_charges,
  input  logic [31:0]          exclusion_dist_sq,
  input  logic signed [31:0]   accel_scale,
  output logic                 res_valid,
  output cfs_pkg::res_t        res,
  input  logic                 res_ready
);
  import cfs_pkg::*;

  localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int IW = $clog2(MAX_CHARGES + 1);
  localparam int SQ_STEPS = ROOT_W;
  localparam logic signed [63:0] ACC_HI = 64'sd1099511627775;
  localparam logic signed [63:0] ACC_LO = -64'sd1099511627776;
  localparam logic signed [ACC_W-1:0] O_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] O_LO = ACC_W'(-64'sd2147483648);
  localparam logic signed [47:0] A_HI = 48'sd2147483647;
  localparam logic signed [47:0] A_LO = -48'sd2147483648;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_DIFF, ST_MUL, ST_CHK, ST_SQRT, ST_DEN, ST_DIVS, ST_DIV,
    ST_ACC, ST_FIN1, ST_FIN2, ST_FIN3
  } state_t;

  state_t                    state_r;
  logic [IW-1:0]             i_r, n_r;
  logic signed [POS_W-1:0]   px_r, py_r;
  logic signed [DIFF_W-1:0]  dx_r, dy_r;
  logic signed [STR_W-1:0]   s_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r;
  logic signed [PRD_W-1:0]   prx_r, pry_r;
  logic [D_W-1:0]            d_r;
  logic [41:0]               xs_r;
  logic [21:0]               rem_r;
  logic [ROOT_W-1:0]         root_r;
  logic [4:0]                sc_r;
  logic [DEN_W-1:0]          den_r;
  logic signed [ACC_W-1:0]   sx_r, sy_r;
  logic signed [OUT_W-1:0]   fx_r, fy_r;
  logic signed [63:0]        pax_r, pay_r;
  logic                      sat_r;

  logic [RAM_W-1:0]          rdata;
  logic [8:0]                widx;
  logic                      ram_we;
  logic [D_W-1:0]            d_sum;
  logic [23:0]               rem_sh, trial;
  logic                      sq_bit;
  logic                      div_start, done_x, done_y;
  logic signed [NUM_W-1:0]   qx, qy;
  logic signed [63:0]        sumx, sumy;
  logic signed [47:0]        shx, shy;
  logic [IW-1:0]             i_inc;
  logic [IW-1:0]             n_sel;

  assign widx   = 9'(q_item.idx);
  assign ram_we = (state_r == ST_IDLE) && q_valid && (q_item.kind == KIND_LOAD);
  assign q_pop  = (state_r == ST_IDLE) && q_valid;

  cfs_ram #(.WIDTH(RAM_W), .DEPTH(MAX_CHARGES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx[AW-1:0]),
    .wdata ({q_item.px, q_item.py, q_item.s}),
    .raddr (i_r[AW-1:0]),
    .rdata (rdata)
  );

  assign div_start = (state_r == ST_DIVS);

  cfs_div u_div_x (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .num ({prx_r, 12'b0}), .den (den_r), .done (done_x), .quot (qx)
  );

  cfs_div u_div_y (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .num ({pry_r, 12'b0}), .den (den_r), .done (done_y), .quot (qy)
  );

  assign n_sel  = (32'(active_charges) < MAX_CHARGES) ? IW'(active_charges) : IW'(MAX_CHARGES);
  assign d_sum  = D_W'(sqx_r) + D_W'(sqy_r);
  assign rem_sh = {rem_r, xs_r[41:40]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign sq_bit = (rem_sh >= trial);
  assign sumx   = 64'(sx_r) + 64'(qx);
  assign sumy   = 64'(sy_r) + 64'(qy);
  assign shx    = 48'(pax_r >>> 16);
  assign shy    = 48'(pay_r >>> 16);
  assign i_inc  = i_r + 1'b1;

  assign res_valid = (state_r == ST_FIN3);
  assign res.fx    = fx_r;
  assign res.fy    = fy_r;
  assign res.ax    = (shx > A_HI) ? OUT_W'(A_HI) : (shx < A_LO) ? OUT_W'(A_LO) : OUT_W'(shx);
  assign res.ay    = (shy > A_HI) ? OUT_W'(A_HI) : (shy < A_LO) ? OUT_W'(A_LO) : OUT_W'(shy);
  assign res.sat   = sat_r || (shx > A_HI) || (shx < A_LO) || (shy > A_HI) || (shy < A_LO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      n_r     <= '0;
      sat_r   <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid && q_item.kind == KIND_QUERY) begin
            px_r  <= q_item.px;
            py_r  <= q_item.py;
            n_r   <= n_sel;
            i_r   <= '0;
            sx_r  <= '0;
            sy_r  <= '0;
            sat_r <= 1'b0;
            state_r <= (n_sel == '0) ? ST_FIN1 : ST_RD;
          end
        end
        ST_RD: state_r <= ST_DIFF;
        ST_DIFF: begin
          dx_r <= DIFF_W'(px_r) - DIFF_W'($signed(rdata[RAM_W-1 -: POS_W]));
          dy_r <= DIFF_W'(py_r) - DIFF_W'($signed(rdata[STR_W +: POS_W]));
          s_r  <= $signed(rdata[STR_W-1:0]);
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          sqx_r <= SQ_W'(dx_r * dx_r);
          sqy_r <= SQ_W'(dy_r * dy_r);
          prx_r <= PRD_W'(s_r) * PRD_W'(dx_r);
          pry_r <= PRD_W'(s_r) * PRD_W'(dy_r);
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          d_r    <= d_sum;
          xs_r   <= {1'b0, d_sum, 8'b0};
          rem_r  <= '0;
          root_r <= '0;
          sc_r   <= '0;
          // skip charges inside the exclusion radius
          if (d_sum <= D_W'(exclusion_dist_sq)) begin
            i_r     <= i_inc;
            state_r <= (i_inc == n_r) ? ST_FIN1 : ST_RD;
          end else begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          rem_r  <= sq_bit ? 22'(rem_sh - trial) : rem_sh[21:0];
          root_r <= {root_r[ROOT_W-2:0], sq_bit};
          xs_r   <= {xs_r[39:0], 2'b00};
          sc_r   <= sc_r + 1'b1;
          if (sc_r == 5'(SQ_STEPS - 1)) begin
            state_r <= ST_DEN;
          end
        end
        ST_DEN: begin
          den_r   <= DEN_W'(d_r) * DEN_W'(root_r);
          state_r <= ST_DIVS;
        end
        ST_DIVS: state_r <= ST_DIV;
        ST_DIV: begin
          if (done_x) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          sx_r <= (sumx > ACC_HI) ? ACC_W'(ACC_HI) : (sumx < ACC_LO) ? ACC_W'(ACC_LO)
                                                                      : ACC_W'(sumx);
          sy_r <= (sumy > ACC_HI) ? ACC_W'(ACC_HI) : (sumy < ACC_LO) ? ACC_W'(ACC_LO)
                                                                      : ACC_W'(sumy);
          if (sumx > ACC_HI || sumx < ACC_LO || sumy > ACC_HI || sumy < ACC_LO) begin
            sat_r <= 1'b1;
          end
          i_r     <= i_inc;
          state_r <= (i_inc == n_r) ? ST_FIN1 : ST_RD;
        end
        ST_FIN1: begin
          fx_r <= (sx_r > O_HI) ? OUT_W'(O_HI) : (sx_r < O_LO) ? OUT_W'(O_LO) : OUT_W'(sx_r);
          fy_r <= (sy_r > O_HI) ? OUT_W'(O_HI) : (sy_r < O_LO) ? OUT_W'(O_LO) : OUT_W'(sy_r);
          if (sx_r > O_HI || sx_r < O_LO || sy_r > O_HI || sy_r < O_LO) begin
            sat_r <= 1'b1;
          end
          state_r <= ST_FIN2;
        end
        ST_FIN2: begin
          pax_r   <= 64'(fx_r) * 64'(accel_scale);
          pay_r   <= 64'(fy_r) * 64'(accel_scale);
          state_r <= ST_FIN3;
        end
        ST_FIN3: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    64'(sx_r) <= ACC_HI && 64'(sx_r) >= ACC_LO)
    else $error("running sum out of clamp range");
  a_index_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> i_r < n_r)
    else $error("charge index past active count");
  a_div_together: assert property (@(posedge clk) disable iff (!rst_n)
    done_x == done_y)
    else $error("x and y dividers out of step");
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DEN |-> (42'(root_r) * 42'(root_r)) <= {1'b0, d_r, 8'b0})
    else $error("square root overshoots");
`endif

endmodule

// File: rtl/coulomb_field_superposition.sv
// Top level of the Coulomb field superposition block: register port, output stage.
// Depends on cfs_pkg, cfs_front, cfs_back (and through them cfs_ram, cfs_div).
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_push / in_full): each beat is a load (in_kind = 0) that writes
//   one charge entry, or a query (in_kind = 1) that asks for the field at a point.
//   Loads give no result; loads aimed past the table are dropped. Queries give one
//   result beat on the output channel (out_empty / out_pop).
//   Configuration registers at byte offsets 0, 4, 8: active charge count, exclusion
//   squared distance, acceleration scale. Write them only while the block is idle.
// Query flow:
//   A load is written into the table by the back end from its idle state. A query
//   walks the N summed charges in turn: per charge fetch and multiply, the
//   bit-serial square root, the denominator, then the radix-2 dividers (one for x,
//   one for y), which take longest; skipped charges leave out root and division.
//   A two-entry queue sits between front and back so the input keeps taking beats.
// Reset: rst_n (synchronous, active low) empties the queue and the output stage and
//   restores register defaults. The charge table is not cleared.
// Stall: while the output beat is not popped the back end holds its last step;
//   the queue fills and in_full rises.
module coulomb_field_superposition #(
  parameter int MAX_CHARGES = cfs_pkg::MAX_CHARGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_kind,
  input  logic [cfs_pkg::IDX_W-1:0]            in_charge_index,
  input  logic signed [cfs_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [cfs_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [cfs_pkg::STR_W-1:0]     in_strength,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [cfs_pkg::OUT_W-1:0]     out_field_x,
  output logic signed [cfs_pkg::OUT_W-1:0]     out_field_y,
  output logic signed [cfs_pkg::OUT_W-1:0]     out_accel_x,
  output logic signed [cfs_pkg::OUT_W-1:0]     out_accel_y,
  output logic                                 out_saturated,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [3:0]                           cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);
  import cfs_pkg::*;

  logic [4:0]         active_r;
  logic [31:0]        excl_r;
  logic signed [31:0] scale_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  item_t in_item, q_item;
  logic  q_valid, q_pop;
  res_t  res, out_r;
  logic  res_valid, res_ready;
  logic  out_valid_r;

  // register port: always ready, writes land on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
      excl_r   <= EXCL_RST;
      scale_r  <= SCALE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ACTIVE: active_r <= cfg_pwdata[4:0];
        REG_EXCL:   excl_r   <= cfg_pwdata;
        REG_SCALE:  scale_r  <= cfg_pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACTIVE: cfg_prdata = 32'(active_r);
      REG_EXCL:   cfg_prdata = excl_r;
      REG_SCALE:  cfg_prdata = scale_r;
      default:    cfg_prdata = '0;
    endcase
  end

  assign in_item.kind = in_kind;
  assign in_item.idx  = in_charge_index;
  assign in_item.px   = in_pos_x;
  assign in_item.py   = in_pos_y;
  assign in_item.s    = in_strength;

  cfs_front #(.MAX_CHARGES(MAX_CHARGES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .item    (in_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  cfs_back #(.MAX_CHARGES(MAX_CHARGES)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .active_charges    (active_r),
    .exclusion_dist_sq (excl_r),
    .accel_scale       (scale_r),
    .res_valid         (res_valid),
    .res               (res),
    .res_ready         (res_ready)
  );

  // output stage: take a new result when empty or being popped
  assign res_ready = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_field_x   = out_r.fx;
  assign out_field_y   = out_r.fy;
  assign out_accel_x   = out_r.ax;
  assign out_accel_y   = out_r.ay;
  assign out_saturated = out_r.sat;

endmodule
